// ----- rtl/wdfg_pkg.sv -----
`default_nettype none

package wdfg_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_FRAME_CONTROL    = 3'd0,
      CSR_DURATION_ID      = 3'd1,
      CSR_DEST_ADDRESS     = 3'd2,
      CSR_SOURCE_ADDRESS   = 3'd3,
      CSR_BSSID_ADDRESS    = 3'd4,
      CSR_SEQUENCE_CONTROL = 3'd5,
      CSR_PRBS_SEED        = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_NO_FRAME   = 2'd2
   } status_type;

   // what the back end does with one queued command
   typedef enum logic [2:0] {
      OP_HEADER     = 3'd0,
      OP_COUNT      = 3'd1,
      OP_PRBS       = 3'd2,
      OP_FCS        = 3'd3,
      OP_BAD_LENGTH = 3'd4,
      OP_NO_FRAME   = 3'd5
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] value;    // header or counter byte
      logic [1:0] fcs_sel;  // fcs byte number, low byte first
      logic       first;    // first byte of a frame, crc restarts
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [15:0] frame_control;
      logic [15:0] duration_id;
      logic [47:0] dest_address;
      logic [47:0] source_address;
      logic [47:0] bssid_address;
      logic [15:0] sequence_control;
   } csr_regs_type;

   localparam logic [15:0] RESET_FRAME_CONTROL    = 16'h0008;
   localparam logic [15:0] RESET_DURATION_ID      = 16'h0000;
   localparam logic [47:0] RESET_DEST_ADDRESS     = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] RESET_SOURCE_ADDRESS   = 48'h000E_4C00_0001;
   localparam logic [47:0] RESET_BSSID_ADDRESS    = 48'h0010_2030_4050;
   localparam logic [15:0] RESET_SEQUENCE_CONTROL = 16'h1870;
   localparam logic [30:0] RESET_PRBS_SEED        = 31'h007F_FFFF;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;

   localparam logic [15:0] ACK_FC_KEEP = 16'h1003;
   localparam logic [15:0] ACK_FC_TYPE = 16'h00D4;  // type control, subtype ack

   localparam int ACK_LENGTH      = 14;
   localparam int MIN_DATA_LENGTH = 28;
   localparam int HEADER_BYTES    = 24;
   localparam int FCS_BYTES       = 4;

endpackage

`default_nettype wire

// ----- rtl/wdfg_csr.sv -----
`default_nettype none

module wdfg_csr
   import wdfg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   input  wire logic [2:0]   csr_index,
   input  wire logic [47:0]  csr_data,
   output csr_regs_type      regs,
   output logic              seed_load,
   output logic [30:0]       seed_value
);

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   always_comb begin
      regs_in    = regs_ff;
      seed_load  = 1'b0;
      seed_value = csr_data[30:0];
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_CONTROL:    regs_in.frame_control    = csr_data[15:0];
            CSR_DURATION_ID:      regs_in.duration_id      = csr_data[15:0];
            CSR_DEST_ADDRESS:     regs_in.dest_address     = csr_data;
            CSR_SOURCE_ADDRESS:   regs_in.source_address   = csr_data;
            CSR_BSSID_ADDRESS:    regs_in.bssid_address    = csr_data;
            CSR_SEQUENCE_CONTROL: regs_in.sequence_control = csr_data[15:0];
            CSR_PRBS_SEED:        seed_load                = 1'b1;
            default:              regs_in                  = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.frame_control    <= RESET_FRAME_CONTROL;
         regs_ff.duration_id      <= RESET_DURATION_ID;
         regs_ff.dest_address     <= RESET_DEST_ADDRESS;
         regs_ff.source_address   <= RESET_SOURCE_ADDRESS;
         regs_ff.bssid_address    <= RESET_BSSID_ADDRESS;
         regs_ff.sequence_control <= RESET_SEQUENCE_CONTROL;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

// ----- rtl/wdfg_front.sv -----
`default_nettype none

module wdfg_front
   import wdfg_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic         start,
   input  wire logic [15:0]  frame_length,
   input  wire logic         body_type,
   input  wire logic         broadcast,
   input  wire csr_regs_type regs,
   output cmd_type           cmd
);

   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int EXT_W = (LEN_W + 1 > 8) ? LEN_W + 1 : 8;

   logic             active_ff, active_in;
   logic [LEN_W-1:0] index_ff, index_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             ack_ff, ack_in;
   logic             bcast_ff, bcast_in;
   logic             prbs_ff, prbs_in;

   logic             is_ack, is_data, cmd_ok;
   logic [LEN_W-1:0] cur_index, cur_length;
   logic             cur_ack, cur_bcast, cur_prbs;
   logic [EXT_W-1:0] idx_x, len_x, idx_plus4;
   logic             in_fcs, is_last;

   function automatic logic [7:0] octet(input logic [47:0] addr, input logic [2:0] k);
      return addr[8 * (5 - k) +: 8];
   endfunction

   function automatic logic [7:0] header_byte(input logic [4:0] i, input logic ack,
                                              input logic bc, input csr_regs_type r);
      logic [15:0] fc;
      fc = ack ? ((r.frame_control & ACK_FC_KEEP) | ACK_FC_TYPE) : r.frame_control;
      priority if (i < 5'd2)  return fc[8 * i[0] +: 8];
      else if (i < 5'd4)      return r.duration_id[8 * i[0] +: 8];
      else if (ack)           return octet(r.source_address, 3'(i - 5'd4));
      else if (i < 5'd10)     return bc ? 8'hFF : octet(r.dest_address, 3'(i - 5'd4));
      else if (i < 5'd16)     return octet(r.source_address, 3'(i - 5'd10));
      else if (i < 5'd22)     return octet(r.bssid_address, 3'(i - 5'd16));
      else                    return r.sequence_control[8 * (i == 5'd23) +: 8];
   endfunction

   always_comb begin
      is_ack  = frame_length == 16'(ACK_LENGTH);
      is_data = (frame_length >= 16'(MIN_DATA_LENGTH))
                && (32'(frame_length) <= 32'(MAX_FRAME_BYTES));
      cmd_ok  = start ? (is_ack || is_data) : active_ff;

      if (start) begin
         cur_index  = '0;
         cur_length = LEN_W'(frame_length);
         cur_ack    = is_ack;
         cur_bcast  = broadcast;
         cur_prbs   = body_type;
      end else begin
         cur_index  = index_ff;
         cur_length = length_ff;
         cur_ack    = ack_ff;
         cur_bcast  = bcast_ff;
         cur_prbs   = prbs_ff;
      end

      idx_x     = EXT_W'(cur_index);
      len_x     = EXT_W'(cur_length);
      idx_plus4 = idx_x + EXT_W'(FCS_BYTES);
      in_fcs    = idx_plus4 >= len_x;
      is_last   = (idx_x + EXT_W'(1)) >= len_x;

      cmd.value   = '0;
      cmd.fcs_sel = 2'(idx_plus4 - len_x);
      cmd.first   = start && cmd_ok;
      cmd.last    = cmd_ok && is_last;
      priority if (!cmd_ok) begin
         cmd.op = start ? OP_BAD_LENGTH : OP_NO_FRAME;
      end else if (in_fcs) begin
         cmd.op = OP_FCS;
      end else if (cur_ack || idx_x < EXT_W'(HEADER_BYTES)) begin
         cmd.op    = OP_HEADER;
         cmd.value = header_byte(idx_x[4:0], cur_ack, cur_bcast, regs);
      end else if (cur_prbs) begin
         cmd.op = OP_PRBS;
      end else begin
         cmd.op    = OP_COUNT;
         cmd.value = 8'(idx_x - EXT_W'(HEADER_BYTES));
      end

      active_in = active_ff;
      index_in  = index_ff;
      length_in = length_ff;
      ack_in    = ack_ff;
      bcast_in  = bcast_ff;
      prbs_in   = prbs_ff;
      if (push) begin
         if (start && !cmd_ok) begin
            active_in = 1'b0;
         end else if (cmd_ok) begin
            active_in = !is_last;
            index_in  = LEN_W'(idx_x + EXT_W'(1));
            length_in = cur_length;
            ack_in    = cur_ack;
            bcast_in  = cur_bcast;
            prbs_in   = cur_prbs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         index_ff  <= '0;
         length_ff <= '0;
         ack_ff    <= 1'b0;
         bcast_ff  <= 1'b0;
         prbs_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         index_ff  <= index_in;
         length_ff <= length_in;
         ack_ff    <= ack_in;
         bcast_ff  <= bcast_in;
         prbs_ff   <= prbs_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wdfg_queue.sv -----
`default_nettype none

module wdfg_queue
   import wdfg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
      full      = count_ff == 2'd2;
      pop_valid = count_ff != 2'd0;
      pop_cmd   = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wdfg_back.sv -----
`default_nettype none

module wdfg_back
   import wdfg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_pop,
   input  wire logic        seed_load,
   input  wire logic [30:0] seed_value,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser
);

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff;
   logic        out_last_ff;
   status_type  out_status_ff;
   logic [31:0] crc_ff, crc_in;
   logic [30:0] prbs_ff, prbs_in;

   logic [7:0]  byte_val;
   logic [31:0] crc_base, fcs_word;
   logic [30:0] prbs_cur;
   status_type  status_val;
   logic        is_content;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] a;
      a = {24'd0, c[7:0] ^ b};
      for (int j = 0; j < 8; j++) begin
         a = (a[0] ? CRC_POLY : 32'd0) ^ (a >> 1);
      end
      return a ^ (c >> 8);
   endfunction

   function automatic logic [30:0] prbs_advance(input logic [30:0] x);
      logic [30:0] r;
      r = x;
      for (int j = 0; j < 8; j++) begin
         r = {r[29:0], r[30] ^ r[27]};
      end
      return r;
   endfunction

   always_comb begin
      cmd_pop    = cmd_valid && (!out_valid_ff || rsp_tready);
      prbs_cur   = (prbs_ff == '0) ? '1 : prbs_ff;
      crc_base   = cmd.first ? CRC_PRESET : crc_ff;
      fcs_word   = ~crc_ff;
      is_content = 1'b0;
      status_val = STATUS_OK;
      byte_val   = 8'd0;
      unique case (cmd.op)
         OP_HEADER, OP_COUNT: begin
            byte_val   = cmd.value;
            is_content = 1'b1;
         end
         OP_PRBS: begin
            byte_val   = prbs_cur[7:0];
            is_content = 1'b1;
         end
         OP_FCS:        byte_val   = fcs_word[8 * cmd.fcs_sel +: 8];
         OP_BAD_LENGTH: status_val = STATUS_BAD_LENGTH;
         OP_NO_FRAME:   status_val = STATUS_NO_FRAME;
         default:       status_val = STATUS_NO_FRAME;
      endcase

      crc_in = crc_ff;
      if (cmd_pop && is_content) begin
         crc_in = crc_byte(crc_base, byte_val);
      end
      prbs_in = prbs_ff;
      if (seed_load) begin
         prbs_in = seed_value;
      end else if (cmd_pop && cmd.op == OP_PRBS) begin
         prbs_in = prbs_advance(prbs_cur);
      end
      out_valid_in = cmd_pop || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         crc_ff       <= CRC_PRESET;
         prbs_ff      <= RESET_PRBS_SEED;
      end else begin
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
         prbs_ff      <= prbs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         out_data_ff   <= byte_val;
         out_last_ff   <= cmd.last;
         out_status_ff <= status_val;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

   a_last_only_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_status_ff == STATUS_OK)
      else $error("last byte flagged on an error response");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != STATUS_OK |-> out_data_ff == 8'd0)
      else $error("error response carries nonzero data");

   a_seed_loads: assert property (@(posedge clock) disable iff (reset)
      seed_load |=> prbs_ff == $past(seed_value))
      else $error("prbs seed write not taken");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd.first && cmd.op == OP_HEADER
      |=> crc_ff == crc_byte(CRC_PRESET, $past(cmd.value)))
      else $error("crc did not restart on first byte");

endmodule

`default_nettype wire

// ----- rtl/wlan_data_frame_generator.sv -----
// 802.11 mpdu byte generator with crc-32 fcs
// req channel: one request per output byte. req_tuser = 1 starts a frame and
//   latches frame_length, body_type and broadcast from req_tdata; req_tuser = 0
//   asks for the next byte of the frame in progress
// rsp channel: one response per request, in order: the byte, tlast on the final
//   fcs byte, and a status in tuser (ok, bad length, no frame in progress)
// csr channel: register writes by index, always ready; write only while idle.
//   writing the prbs seed reloads the body prbs at once
// path: an accepted request is written into the command queue and is moved into the
//   output register once that register is empty or being taken; the response is registered
// throughput: one byte per cycle sustained while rsp_tready stays high; the front
//   end builds a command per request, the back end runs crc and prbs one byte per cycle
// stall: the response holds while rsp_tready is low; the two-entry command queue
//   fills and then req_tready falls
// reset: registers return to defaults, no frame active, crc preset, prbs at the
//   default seed; the prbs state carries over from frame to frame
`default_nettype none

module wlan_data_frame_generator
   import wdfg_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // frame_length[15:0], body_type[16], broadcast[17]
   input  wire logic        req_tuser,   // req_type
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // data_byte[7:0]
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser,   // status[1:0]
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_data
);

   csr_regs_type regs;
   logic         seed_load;
   logic [30:0]  seed_value;
   cmd_type      front_cmd, queue_cmd;
   logic         queue_full, queue_valid, queue_pop;
   logic         req_accept;

   // registers never stall a write
   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   wdfg_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .regs       (regs),
      .seed_load  (seed_load),
      .seed_value (seed_value)
   );

   // frame sequencing: classifies each request and builds its command (header, counter, prbs or fcs byte)
   wdfg_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_accept),
      .start        (req_tuser),
      .frame_length (req_tdata[15:0]),
      .body_type    (req_tdata[16]),
      .broadcast    (req_tdata[17]),
      .regs         (regs),
      .cmd          (front_cmd)
   );

   // decouples request acceptance from response backpressure
   wdfg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_cmd   (queue_cmd)
   );

   // crc, prbs body and the response register
   wdfg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (queue_cmd),
      .cmd_pop    (queue_pop),
      .seed_load  (seed_load),
      .seed_value (seed_value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
